// File: hw/rtl/ohd_pkg.sv
// ordered hash dictionary: shared types and constants
// no dependencies
`timescale 1ns / 1ps
package ohd_pkg;
    localparam int ENTRIES = 64;
    localparam int SLOTS = 128;
    localparam int EW = $clog2(ENTRIES);
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int TW = $clog2(ENTRIES + 1);

    localparam logic [1:0] CMD_SET = 2'd0;
    localparam logic [1:0] CMD_GET = 2'd1;
    localparam logic [1:0] CMD_DEL = 2'd2;
    localparam logic [1:0] CMD_KEYAT = 2'd3;

    localparam logic [2:0] ST_UPDATED = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_HIT = 3'd2;
    localparam logic [2:0] ST_MISS = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR,   // sweep slot table to zero
        S_IDLE,
        S_PROBE,   // issue slot read
        S_TAG,     // slot data back, issue key read
        S_CMP,     // key data back, compare
        S_FREE,    // insert / rebuild placement
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RB_CLR,
        S_RB_KEY,
        S_RB_WAIT,
        S_KEYAT,
        S_KEYAT_W,
        S_VALRD,
        S_VALW,
        S_OUT
    } state_t;
endpackage

// File: hw/rtl/ordered_hash_dictionary.sv
// ordered hash dictionary top level: sequencer, entry memories, slot table
// depends on ohd_pkg
`timescale 1ns / 1ps
// Insertion-ordered key/value store with a linear-probing slot table. One
// request is worked at a time through a small sequencer around memories
// (slot table, entry keys, entry values) with one write port and one
// registered read port each. After reset a clearing pass zeroes the slot
// table before the first request is taken. A lookup reads the home slot,
// then the entry key that it points at, and probes further slots in turn;
// after the lookup a get hit reads the value, an update writes it, and an
// insert writes slot, key and value. A delete shifts the tail of the entry
// array down one entry at a time, clears the slot table and re-places every
// live entry by probing from its home slot; this rebuild dominates. Key-at
// reads the key at the given position. Results sit in an output register;
// a held result blocks the next request until it is taken.
module ordered_hash_dictionary
    import ohd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic signed [63:0] key_word,
    input  logic signed [63:0] value_word,
    input  logic [5:0]         position,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic signed [63:0] value_out,
    output logic signed [63:0] key_out,
    output logic [6:0]         entry_count
);
    logic [63:0] keys_mem [ENTRIES];
    logic [63:0] vals_mem [ENTRIES];
    logic [TW-1:0] slot_mem [SLOTS];

    state_t state_reg, state_next;
    state_t dp_state;
    logic [1:0]  cmd_reg;
    logic [63:0] key_reg, val_reg;
    logic [5:0]  pos_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] slot_reg, slot_next;   // probe slot / clear address
    logic [SW:0]   steps_reg, steps_next; // slots visited
    logic [CW-1:0] idx_reg, idx_next;     // entry index for shift / rebuild
    logic [TW-1:0] tag_q;                 // registered slot read
    logic [63:0] key_q, val_q;            // registered entry reads
    logic [EW-1:0] hit_reg, hit_next;
    logic placing_reg, placing_next;      // probing for an empty slot
    logic [2:0]  st_reg, st_next;
    logic [63:0] vo_reg, vo_next, ko_reg, ko_next;
    logic ov_reg, ov_next;

    // memory control
    logic          s_we, k_we, v_we;
    logic [SW-1:0] s_wa, s_ra;
    logic [TW-1:0] s_wd;
    logic [EW-1:0] k_wa, k_ra, v_wa, v_ra;
    logic [63:0]   k_wd, v_wd;

    logic accept;
    assign in_stall = (state_reg != S_IDLE) || ov_reg;
    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            slot_mem[s_wa] <= s_wd;
        end
        tag_q <= slot_mem[s_ra];
        if (k_we)
        begin
            keys_mem[k_wa] <= k_wd;
        end
        key_q <= keys_mem[k_ra];
        if (v_we)
        begin
            vals_mem[v_wa] <= v_wd;
        end
        val_q <= vals_mem[v_ra];
    end

    // tag decoded
    logic [TW-1:0] tagm1;
    logic tag_live;
    assign tagm1 = tag_q - TW'(1);
    assign tag_live = (tag_q != '0) && ({1'b0, tagm1} < {1'b0, count_reg});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:    if (slot_reg == SW'(SLOTS - 1)) state_next = S_IDLE;
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_KEYAT) state_next = S_KEYAT;
                    else state_next = S_TAG;
                end
            end
            S_PROBE:    state_next = S_TAG;
            S_TAG:
            begin
                if (placing_reg) state_next = S_FREE;
                else if (tag_q == '0) state_next = S_FREE;
                else state_next = S_CMP;
            end
            S_CMP:      state_next = S_FREE;
            S_FREE:     state_next = S_FREE;
            S_SHIFT_RD: state_next = S_SHIFT_WR;
            S_SHIFT_WR: state_next = S_SHIFT_RD;
            S_RB_CLR:   state_next = S_RB_CLR;
            S_RB_KEY:   state_next = S_RB_WAIT;
            S_RB_WAIT:  state_next = S_TAG;
            S_KEYAT:    state_next = S_KEYAT_W;
            S_KEYAT_W:  state_next = S_OUT;
            S_VALRD:    state_next = S_VALW;
            S_VALW:     state_next = S_OUT;
            S_OUT:      state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
        // the decision states pick their successor in the datapath block
        if (state_reg == S_CMP || state_reg == S_FREE || state_reg == S_SHIFT_WR
            || state_reg == S_RB_CLR || (state_reg == S_TAG && !placing_reg
            && tag_q == '0))
        begin
            state_next = dp_state;
        end
    end

    always_comb
    begin
        slot_next = slot_reg;
        steps_next = steps_reg;
        idx_next = idx_reg;
        hit_next = hit_reg;
        placing_next = placing_reg;
        count_next = count_reg;
        st_next = st_reg;
        vo_next = vo_reg;
        ko_next = ko_reg;
        ov_next = ov_reg && out_stall;
        dp_state = S_IDLE;
        s_we = 1'b0;
        s_wa = slot_reg;
        s_wd = '0;
        s_ra = slot_reg;
        k_we = 1'b0;
        k_wa = idx_reg[EW-1:0];
        k_wd = key_reg;
        k_ra = tagm1[EW-1:0];
        v_we = 1'b0;
        v_wa = idx_reg[EW-1:0];
        v_wd = val_reg;
        v_ra = hit_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                s_we = 1'b1;
                slot_next = slot_reg + SW'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    slot_next = key_word[SW-1:0];
                    s_ra = key_word[SW-1:0];
                    steps_next = '0;
                    placing_next = 1'b0;
                    st_next = ST_MISS;
                    vo_next = '0;
                    ko_next = '0;
                    k_ra = position[EW-1:0];
                end
            end
            S_PROBE:
            begin
            end
            S_TAG:
            begin
                // key read issued at tagm1 by default
                if (!placing_reg && tag_q == '0)
                begin
                    // miss: a set goes on to place, others finish
                    if (cmd_reg == CMD_SET)
                    begin
                        dp_state = S_FREE;
                    end
                    else
                    begin
                        dp_state = S_OUT;
                    end
                end
            end
            S_CMP:
            begin
                if (tag_live && key_q == key_reg)
                begin
                    hit_next = tagm1[EW-1:0];
                    if (cmd_reg == CMD_SET)
                    begin
                        v_we = 1'b1;
                        v_wa = tagm1[EW-1:0];
                        st_next = ST_UPDATED;
                        dp_state = S_OUT;
                    end
                    else if (cmd_reg == CMD_GET)
                    begin
                        st_next = ST_HIT;
                        dp_state = S_VALRD;
                    end
                    else
                    begin
                        st_next = ST_HIT;
                        idx_next = {1'b0, tagm1[EW-1:0]};
                        dp_state = S_SHIFT_RD;
                    end
                end
                else if (steps_reg == (SW+1)'(SLOTS - 1))
                begin
                    dp_state = (cmd_reg == CMD_SET) ? S_FREE : S_OUT;
                    if (cmd_reg == CMD_SET)
                    begin
                        // no empty slot met: restart from home to place
                        slot_next = key_reg[SW-1:0];
                        steps_next = '0;
                        placing_next = 1'b1;
                        dp_state = S_PROBE;
                    end
                end
                else
                begin
                    slot_next = slot_reg + SW'(1);
                    steps_next = steps_reg + (SW+1)'(1);
                    dp_state = S_PROBE;
                end
            end
            S_FREE:
            begin
                // slot_reg holds a just-read slot; tag_q valid when entered via TAG
                if (!placing_reg && cmd_reg == CMD_SET)
                begin
                    // came from a miss on an empty slot: that slot is the place
                    if (count_reg >= CW'(ENTRIES))
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        s_we = 1'b1;
                        s_wd = TW'(count_reg) + TW'(1);
                        k_we = 1'b1;
                        v_we = 1'b1;
                        k_wa = count_reg[EW-1:0];
                        v_wa = count_reg[EW-1:0];
                        count_next = count_reg + CW'(1);
                        st_next = ST_INSERTED;
                    end
                    dp_state = S_OUT;
                end
                else if (tag_q == '0)
                begin
                    if (cmd_reg == CMD_SET)
                    begin
                        if (count_reg >= CW'(ENTRIES))
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            s_we = 1'b1;
                            s_wd = TW'(count_reg) + TW'(1);
                            k_we = 1'b1;
                            v_we = 1'b1;
                            k_wa = count_reg[EW-1:0];
                            v_wa = count_reg[EW-1:0];
                            count_next = count_reg + CW'(1);
                            st_next = ST_INSERTED;
                        end
                        dp_state = S_OUT;
                    end
                    else
                    begin
                        // rebuild placement of entry idx_reg
                        s_we = 1'b1;
                        s_wd = TW'(idx_reg) + TW'(1);
                        idx_next = idx_reg + CW'(1);
                        dp_state = (idx_reg + CW'(1) >= count_reg) ? S_OUT : S_RB_KEY;
                    end
                end
                else if (steps_reg == (SW+1)'(SLOTS - 1))
                begin
                    if (cmd_reg == CMD_SET)
                    begin
                        st_next = ST_FULL;
                        dp_state = S_OUT;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                        dp_state = (idx_reg + CW'(1) >= count_reg) ? S_OUT : S_RB_KEY;
                    end
                end
                else
                begin
                    slot_next = slot_reg + SW'(1);
                    steps_next = steps_reg + (SW+1)'(1);
                    dp_state = S_PROBE;
                end
            end
            S_SHIFT_RD:
            begin
                k_ra = EW'(idx_reg + CW'(1));
                v_ra = EW'(idx_reg + CW'(1));
            end
            S_SHIFT_WR:
            begin
                if (idx_reg + CW'(1) < count_reg)
                begin
                    k_we = 1'b1;
                    v_we = 1'b1;
                    k_wd = key_q;
                    v_wd = val_q;
                    idx_next = idx_reg + CW'(1);
                    dp_state = S_SHIFT_RD;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    slot_next = '0;
                    dp_state = S_RB_CLR;
                end
            end
            S_RB_CLR:
            begin
                s_we = 1'b1;
                slot_next = slot_reg + SW'(1);
                dp_state = S_RB_CLR;
                if (slot_reg == SW'(SLOTS - 1))
                begin
                    idx_next = '0;
                    placing_next = 1'b1;
                    dp_state = (count_reg == '0) ? S_OUT : S_RB_KEY;
                end
            end
            S_RB_KEY:
            begin
                k_ra = idx_reg[EW-1:0];
            end
            S_RB_WAIT:
            begin
                slot_next = key_q[SW-1:0];
                s_ra = key_q[SW-1:0];
                steps_next = '0;
            end
            S_KEYAT:
            begin
                // key read at the requested position
                k_ra = pos_reg[EW-1:0];
            end
            S_KEYAT_W:
            begin
                if ({1'b0, pos_reg} < 7'(count_reg))
                begin
                    ko_next = key_q;
                    st_next = ST_HIT;
                end
            end
            S_VALRD:
            begin
            end
            S_VALW:
            begin
                vo_next = val_q;
            end
            S_OUT:
            begin
                ov_next = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_PROBE)
        begin
            s_ra = slot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            count_reg <= '0;
            slot_reg <= '0;
            ov_reg <= 1'b0;
            placing_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            slot_reg <= slot_next;
            ov_reg <= ov_next;
            placing_reg <= placing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            key_reg <= key_word;
            val_reg <= value_word;
            pos_reg <= position;
        end
        steps_reg <= steps_next;
        idx_reg <= idx_next;
        hit_reg <= hit_next;
        st_reg <= st_next;
        vo_reg <= vo_next;
        ko_reg <= ko_next;
    end

    assign out_valid = ov_reg;
    assign status = st_reg;
    assign value_out = vo_reg;
    assign key_out = ko_reg;
    assign entry_count = 7'(count_reg);

    // live count never exceeds capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ENTRIES))
        else $error("entry count above capacity");

    // nothing taken while a result is held
    a_no_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> !accept)
        else $error("request taken with result pending");

    // count moves by at most one per cycle
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        (count_reg == $past(count_reg) + CW'(1) || count_reg == $past(count_reg) - CW'(1)))
        else $error("entry count jumped");
endmodule
